FILE: rtl/core/rpnc_pkg.sv
`default_nettype none

package rpnc_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int SP_AW = $clog2(STACK_DEPTH);
  localparam int SP_W = SP_AW + 1;
  localparam int MAX_FRAC_DIGITS = 9;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    KIND_VALUE   = 3'd0,
    KIND_FULL    = 3'd1,
    KIND_EMPTY   = 3'd2,
    KIND_ZDIV    = 3'd3,
    KIND_UNKNOWN = 3'd4
  } res_kind_e;

  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_MINUS = 2'd1,
    PEND_INT   = 2'd2,
    PEND_FRAC  = 2'd3
  } pend_e;

  typedef enum logic [2:0] {
    AOP_ADD = 3'd0,
    AOP_SUB = 3'd1,
    AOP_MUL = 3'd2,
    AOP_DIV = 3'd3,
    AOP_REM = 3'd4
  } arith_e;

  typedef enum logic [1:0] {
    RSRC_ZERO  = 2'd0,
    RSRC_RDATA = 2'd1,
    RSRC_CHAR  = 2'd2
  } res_src_e;

  typedef enum logic [3:0] {
    DP_NONE        = 4'd0,
    DP_MINUS_NUM   = 4'd1,
    DP_DIGIT       = 4'd2,
    DP_POINT       = 4'd3,
    DP_START_DIGIT = 4'd4,
    DP_SET_MINUS   = 4'd5,
    DP_CLEAR       = 4'd6,
    DP_FIN_START   = 4'd7,
    DP_FIN_PUSH    = 4'd8,
    DP_POP         = 4'd9,
    DP_LATCH_B     = 4'd10,
    DP_LATCH_A     = 4'd11,
    DP_ALU         = 4'd12,
    DP_MUL_START   = 4'd13,
    DP_DIV_START   = 4'd14,
    DP_WRITE_RES   = 4'd15
  } dp_op_e;

  typedef struct packed {
    logic      load_in;
    dp_op_e    op;
    arith_e    aop;
    logic      res_push;
    logic      res_idx;
    res_kind_e res_kind;
    res_src_e  res_src;
    logic      out_load;
    logic      out_idx;
    logic      out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       eos;
    pend_e      pend;
    logic       sp_zero;
    logic       sp_lt2;
    logic       sp_full;
    logic       b_zero;
    logic       unit_busy;
    logic       out_free;
  } dp_stat_t;

  function automatic logic [29:0] pow10(input logic [3:0] n);
    logic [29:0] r;
    unique case (n)
      4'd0: r = 30'd1;
      4'd1: r = 30'd10;
      4'd2: r = 30'd100;
      4'd3: r = 30'd1000;
      4'd4: r = 30'd10000;
      4'd5: r = 30'd100000;
      4'd6: r = 30'd1000000;
      4'd7: r = 30'd10000000;
      4'd8: r = 30'd100000000;
      default: r = 30'd1000000000;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rpnc_div.sv
`default_nettype none

module rpnc_div
  import rpnc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [95:0] num_i,
  input  wire logic [63:0] den_i,
  output logic             busy_o,
  output logic [95:0]      quo_o,
  output logic [63:0]      rem_o
);

  logic        busy_q;
  logic [6:0]  cnt_q;
  logic [95:0] quo_q;
  logic [63:0] rem_q;
  logic [63:0] den_q;
  logic [64:0] part;
  logic [64:0] diff;
  logic        ge;

  assign part = {rem_q, quo_q[95]};
  assign diff = part - {1'b0, den_q};
  assign ge   = part >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 7'd95;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 7'd1;
      if (cnt_q == 7'd0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[94:0], ge};
      rem_q <= ge ? diff[63:0] : part[63:0];
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

FILE: rtl/core/rpnc_mul.sv
`default_nettype none

module rpnc_mul
  import rpnc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] a_i,
  input  wire logic [63:0] b_i,
  output logic             busy_o,
  output logic [127:0]     prod_o
);

  logic         busy_q;
  logic [2:0]   step_q;
  logic         pv_q;
  logic [63:0]  a_q;
  logic [63:0]  b_q;
  logic [63:0]  prod_q;
  logic [1:0]   sh_q;
  logic [127:0] acc_q;
  logic [31:0]  x;
  logic [31:0]  y;
  logic [1:0]   sh;
  logic [127:0] addend;

  assign x  = step_q[1] ? a_q[63:32] : a_q[31:0];
  assign y  = step_q[0] ? b_q[63:32] : b_q[31:0];
  assign sh = {step_q[1] & step_q[0], step_q[1] ^ step_q[0]};

  always_comb begin
    unique case (sh_q)
      2'd0:    addend = {64'd0, prod_q};
      2'd1:    addend = {32'd0, prod_q, 32'd0};
      default: addend = {prod_q, 64'd0};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      pv_q   <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
      pv_q   <= 1'b0;
    end else if (busy_q) begin
      step_q <= step_q + 3'd1;
      pv_q   <= step_q != 3'd4;
      if (step_q == 3'd4) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      if (step_q != 3'd4) begin
        prod_q <= {32'd0, x} * {32'd0, y};
        sh_q   <= sh;
      end
      if (pv_q) begin
        acc_q <= acc_q + addend;
      end
    end
  end

  assign busy_o = busy_q;
  assign prod_o = acc_q;

endmodule

`default_nettype wire

FILE: rtl/core/rpnc_dp.sv
`default_nettype none

module rpnc_dp
  import rpnc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire dp_cmd_t     cmd_i,
  output dp_stat_t         stat_o,
  input  wire logic [7:0]  in_char_i,
  input  wire logic        in_eos_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      out_value_o,
  output logic [2:0]       out_kind_o,
  output logic             out_last_o
);

  logic [63:0] stack_mem [STACK_DEPTH];
  logic [63:0] rdata_q;

  logic [SP_W-1:0] sp_q;
  pend_e           pend_q;
  logic            neg_q;
  logic [31:0]     int_q;
  logic [29:0]     frac_q;
  logic [3:0]      fcnt_q;

  logic [7:0]  char_q;
  logic        eos_q;
  logic [63:0] a_q;
  logic [63:0] b_q;

  logic [2:0]  hold_kind_q [2];
  logic [63:0] hold_val_q [2];
  logic        out_valid_q;
  logic [2:0]  out_kind_q;
  logic [63:0] out_val_q;
  logic        out_last_q;

  logic [SP_AW-1:0] top_idx;
  logic [SP_AW-1:0] mem_wa;
  logic             mem_we;
  logic [63:0]      mem_wd;
  logic             sp_full;

  logic [3:0]  digit;
  logic [35:0] int_next;
  logic [29:0] den;
  logic [64:0] fin_mag;
  logic [63:0] fin_val;
  logic [63:0] mag_a;
  logic [63:0] mag_b;
  logic        res_neg;
  logic [63:0] sum;
  logic [63:0] dif;
  logic [63:0] alu_res;
  logic [63:0] unit_res;

  logic         div_start;
  logic [95:0]  div_num;
  logic [63:0]  div_den;
  logic         div_busy;
  logic [95:0]  quo;
  logic [63:0]  rem;
  logic         mul_start;
  logic         mul_busy;
  logic [127:0] prod;

  logic [63:0] res_val;

  function automatic logic [63:0] from_mag(input logic neg, input logic [63:0] mag,
                                           input logic ovf);
    logic [63:0] r;
    if (neg) begin
      r = (ovf || mag > 64'h8000_0000_0000_0000) ? 64'h8000_0000_0000_0000 : -mag;
    end else begin
      r = (ovf || mag[63]) ? 64'h7FFF_FFFF_FFFF_FFFF : mag;
    end
    return r;
  endfunction

  function automatic logic [63:0] mag_of(input logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  assign top_idx = SP_AW'(sp_q - SP_W'(1));
  assign sp_full = sp_q == SP_W'(STACK_DEPTH);
  assign digit   = char_q[3:0];
  assign int_next = {int_q, 3'd0} + {3'd0, int_q, 1'b0} + {32'd0, digit};
  assign den     = pow10(fcnt_q);

  assign fin_mag = {1'b0, int_q, 32'd0} + {1'b0, quo[63:0]};
  assign fin_val = from_mag(neg_q, fin_mag[63:0], fin_mag[64]);

  assign mag_a   = mag_of(a_q);
  assign mag_b   = mag_of(b_q);
  assign res_neg = a_q[63] ^ b_q[63];
  assign sum     = a_q + b_q;
  assign dif     = a_q - b_q;

  always_comb begin
    if (cmd_i.aop == AOP_SUB) begin
      alu_res = dif;
      if ((a_q[63] != b_q[63]) && (dif[63] != a_q[63])) begin
        alu_res = a_q[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      end
    end else begin
      alu_res = sum;
      if ((a_q[63] == b_q[63]) && (sum[63] != a_q[63])) begin
        alu_res = a_q[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      end
    end
  end

  always_comb begin
    unique case (cmd_i.aop)
      AOP_MUL: unit_res = from_mag(res_neg, prod[95:32], prod[127:96] != 32'd0);
      AOP_DIV: unit_res = from_mag(res_neg, quo[63:0], quo[95:64] != 32'd0);
      AOP_REM: unit_res = a_q[63] ? -rem : rem;
      default: unit_res = alu_res;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = {34'd0, frac_q, 32'd0} + {67'd0, den[29:1]};
    div_den   = {34'd0, den};
    if (cmd_i.op == DP_FIN_START) begin
      div_start = 1'b1;
    end else if (cmd_i.op == DP_DIV_START) begin
      div_start = 1'b1;
      div_num   = (cmd_i.aop == AOP_DIV) ? {mag_a, 32'd0} : {32'd0, mag_a};
      div_den   = mag_b;
    end
  end

  assign mul_start = cmd_i.op == DP_MUL_START;

  rpnc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (quo),
    .rem_o   (rem)
  );

  rpnc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mag_a),
    .b_i     (mag_b),
    .busy_o  (mul_busy),
    .prod_o  (prod)
  );

  always_comb begin
    mem_we = 1'b0;
    mem_wa = top_idx;
    mem_wd = unit_res;
    unique case (cmd_i.op)
      DP_FIN_PUSH: begin
        mem_we = !sp_full;
        mem_wa = sp_q[SP_AW-1:0];
        mem_wd = fin_val;
      end
      DP_ALU: begin
        mem_we = 1'b1;
        mem_wd = alu_res;
      end
      DP_WRITE_RES: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[mem_wa] <= mem_wd;
    end
    rdata_q <= stack_mem[top_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q   <= '0;
      pend_q <= PEND_NONE;
      neg_q  <= 1'b0;
      int_q  <= '0;
      frac_q <= '0;
      fcnt_q <= '0;
    end else begin
      unique case (cmd_i.op)
        DP_MINUS_NUM: begin
          pend_q <= PEND_INT;
          neg_q  <= 1'b1;
          int_q  <= '0;
          frac_q <= '0;
          fcnt_q <= '0;
        end
        DP_DIGIT: begin
          if (pend_q == PEND_INT) begin
            int_q <= (int_next > 36'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : int_next[31:0];
          end else if (fcnt_q < 4'(MAX_FRAC_DIGITS)) begin
            frac_q <= 30'(({frac_q, 3'd0} + {frac_q, 1'b0}) + {29'd0, digit});
            fcnt_q <= fcnt_q + 4'd1;
          end
        end
        DP_POINT: begin
          pend_q <= PEND_FRAC;
        end
        DP_START_DIGIT: begin
          pend_q <= PEND_INT;
          int_q  <= {28'd0, digit};
        end
        DP_SET_MINUS: begin
          pend_q <= PEND_MINUS;
        end
        DP_CLEAR, DP_FIN_PUSH: begin
          pend_q <= PEND_NONE;
          neg_q  <= 1'b0;
          int_q  <= '0;
          frac_q <= '0;
          fcnt_q <= '0;
          if (cmd_i.op == DP_FIN_PUSH && !sp_full) begin
            sp_q <= sp_q + SP_W'(1);
          end
        end
        DP_POP: begin
          sp_q <= sp_q - SP_W'(1);
        end
        default: begin
          sp_q <= sp_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      char_q <= in_char_i;
      eos_q  <= in_eos_i;
    end
    if (cmd_i.op == DP_LATCH_B) begin
      b_q <= rdata_q;
    end
    if (cmd_i.op == DP_LATCH_A) begin
      a_q <= rdata_q;
    end
  end

  always_comb begin
    unique case (cmd_i.res_src)
      RSRC_RDATA: res_val = rdata_q;
      RSRC_CHAR:  res_val = {56'd0, char_q};
      default:    res_val = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_push) begin
      hold_kind_q[cmd_i.res_idx] <= cmd_i.res_kind;
      hold_val_q[cmd_i.res_idx]  <= res_val;
    end
    if (cmd_i.out_load) begin
      out_kind_q <= hold_kind_q[cmd_i.out_idx];
      out_val_q  <= hold_val_q[cmd_i.out_idx];
      out_last_q <= cmd_i.out_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_val_q;
  assign out_kind_o  = out_kind_q;
  assign out_last_o  = out_last_q;

  assign stat_o.char_code = char_q;
  assign stat_o.eos       = eos_q;
  assign stat_o.pend      = pend_q;
  assign stat_o.sp_zero   = sp_q == '0;
  assign stat_o.sp_lt2    = sp_q < SP_W'(2);
  assign stat_o.sp_full   = sp_full;
  assign stat_o.b_zero    = b_q == '0;
  assign stat_o.unit_busy = div_busy | mul_busy;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

FILE: rtl/core/rpnc_ctrl.sv
`default_nettype none

module rpnc_ctrl
  import rpnc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_NUM      = 4'd2;
  localparam logic [3:0] S_POINT    = 4'd3;
  localparam logic [3:0] S_PLAIN    = 4'd4;
  localparam logic [3:0] S_FIN_DIV  = 4'd5;
  localparam logic [3:0] S_FIN_WAIT = 4'd6;
  localparam logic [3:0] S_OP_CHK   = 4'd7;
  localparam logic [3:0] S_OP_B     = 4'd8;
  localparam logic [3:0] S_OP_A     = 4'd9;
  localparam logic [3:0] S_OP_EXEC  = 4'd10;
  localparam logic [3:0] S_OP_WAIT  = 4'd11;
  localparam logic [3:0] S_PR_RD    = 4'd12;
  localparam logic [3:0] S_PR_EMIT  = 4'd13;
  localparam logic [3:0] S_DRAIN    = 4'd14;

  logic [3:0] state_q, state_d;
  logic [3:0] ret_q, ret_d;
  arith_e     aop_q, aop_d;
  logic       halted_q, halted_d;
  logic [1:0] res_cnt_q, res_cnt_d;
  logic       drain_q, drain_d;

  logic       emit_en;
  res_kind_e  emit_kind;
  res_src_e   emit_src;

  logic [7:0] c;
  logic       is_dig;
  logic       is_dot;
  logic       is_op;
  arith_e     char_aop;
  logic       div_like;

  assign c       = stat_i.char_code;
  assign is_dig  = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_dot  = c == CH_DOT;
  assign is_op   = (c == CH_PLUS) || (c == CH_STAR) || (c == CH_SLASH) || (c == CH_PCT);
  assign div_like = (aop_q == AOP_DIV) || (aop_q == AOP_REM);

  always_comb begin
    priority if (c == CH_STAR) begin
      char_aop = AOP_MUL;
    end else if (c == CH_SLASH) begin
      char_aop = AOP_DIV;
    end else if (c == CH_PCT) begin
      char_aop = AOP_REM;
    end else begin
      char_aop = AOP_ADD;
    end
  end

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    aop_d     = aop_q;
    halted_d  = halted_q;
    res_cnt_d = res_cnt_q;
    drain_d   = drain_q;
    emit_en   = 1'b0;
    emit_kind = KIND_VALUE;
    emit_src  = RSRC_ZERO;
    cmd_o     = '0;
    cmd_o.aop = aop_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && !halted_q) begin
          cmd_o.load_in = 1'b1;
          res_cnt_d     = '0;
          drain_d       = 1'b0;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.eos) begin
          unique case (stat_i.pend)
            PEND_MINUS: begin
              cmd_o.op = DP_CLEAR;
              aop_d    = AOP_SUB;
              ret_d    = S_DRAIN;
              state_d  = S_OP_CHK;
            end
            PEND_INT, PEND_FRAC: begin
              ret_d   = S_DRAIN;
              state_d = S_FIN_DIV;
            end
            default: begin
              state_d = S_DRAIN;
            end
          endcase
        end else if (stat_i.pend == PEND_MINUS) begin
          if (is_dig || is_dot) begin
            cmd_o.op = DP_MINUS_NUM;
            state_d  = S_NUM;
          end else begin
            cmd_o.op = DP_CLEAR;
            aop_d    = AOP_SUB;
            ret_d    = S_NUM;
            state_d  = S_OP_CHK;
          end
        end else begin
          state_d = S_NUM;
        end
      end
      S_NUM: begin
        priority if (halted_q) begin
          state_d = S_DRAIN;
        end else if (stat_i.pend == PEND_NONE) begin
          state_d = S_PLAIN;
        end else if (is_dig) begin
          cmd_o.op = DP_DIGIT;
          state_d  = S_DRAIN;
        end else if (is_dot && stat_i.pend == PEND_INT) begin
          cmd_o.op = DP_POINT;
          state_d  = S_DRAIN;
        end else if (is_dot) begin
          ret_d   = S_POINT;
          state_d = S_FIN_DIV;
        end else begin
          ret_d   = S_PLAIN;
          state_d = S_FIN_DIV;
        end
      end
      S_POINT: begin
        cmd_o.op = DP_POINT;
        state_d  = S_DRAIN;
      end
      S_PLAIN: begin
        priority if (c == CH_SPACE || c == CH_TAB) begin
          state_d = S_DRAIN;
        end else if (is_dig) begin
          cmd_o.op = DP_START_DIGIT;
          state_d  = S_DRAIN;
        end else if (is_dot) begin
          cmd_o.op = DP_POINT;
          state_d  = S_DRAIN;
        end else if (c == CH_MINUS) begin
          cmd_o.op = DP_SET_MINUS;
          state_d  = S_DRAIN;
        end else if (is_op) begin
          aop_d   = char_aop;
          ret_d   = S_DRAIN;
          state_d = S_OP_CHK;
        end else if (c == CH_NL) begin
          state_d = S_PR_RD;
        end else begin
          emit_en   = 1'b1;
          emit_kind = KIND_UNKNOWN;
          emit_src  = RSRC_CHAR;
          state_d   = S_DRAIN;
        end
      end
      S_FIN_DIV: begin
        cmd_o.op = DP_FIN_START;
        state_d  = S_FIN_WAIT;
      end
      S_FIN_WAIT: begin
        if (!stat_i.unit_busy) begin
          cmd_o.op  = DP_FIN_PUSH;
          emit_en   = stat_i.sp_full;
          emit_kind = KIND_FULL;
          state_d   = ret_q;
        end
      end
      S_OP_CHK: begin
        if (div_like ? stat_i.sp_zero : stat_i.sp_lt2) begin
          halted_d  = 1'b1;
          emit_en   = 1'b1;
          emit_kind = KIND_EMPTY;
          state_d   = S_DRAIN;
        end else begin
          cmd_o.op = DP_POP;
          state_d  = S_OP_B;
        end
      end
      S_OP_B: begin
        cmd_o.op = DP_LATCH_B;
        state_d  = S_OP_A;
      end
      S_OP_A: begin
        priority if (div_like && stat_i.b_zero) begin
          emit_en   = 1'b1;
          emit_kind = KIND_ZDIV;
          state_d   = ret_q;
        end else if (div_like && stat_i.sp_zero) begin
          halted_d  = 1'b1;
          emit_en   = 1'b1;
          emit_kind = KIND_EMPTY;
          state_d   = S_DRAIN;
        end else begin
          cmd_o.op = DP_LATCH_A;
          state_d  = S_OP_EXEC;
        end
      end
      S_OP_EXEC: begin
        unique case (aop_q)
          AOP_MUL: begin
            cmd_o.op = DP_MUL_START;
            state_d  = S_OP_WAIT;
          end
          AOP_DIV, AOP_REM: begin
            cmd_o.op = DP_DIV_START;
            state_d  = S_OP_WAIT;
          end
          default: begin
            cmd_o.op = DP_ALU;
            state_d  = ret_q;
          end
        endcase
      end
      S_OP_WAIT: begin
        if (!stat_i.unit_busy) begin
          cmd_o.op = DP_WRITE_RES;
          state_d  = ret_q;
        end
      end
      S_PR_RD: begin
        if (stat_i.sp_zero) begin
          halted_d  = 1'b1;
          emit_en   = 1'b1;
          emit_kind = KIND_EMPTY;
          state_d   = S_DRAIN;
        end else begin
          cmd_o.op = DP_POP;
          state_d  = S_PR_EMIT;
        end
      end
      S_PR_EMIT: begin
        emit_en   = 1'b1;
        emit_kind = KIND_VALUE;
        emit_src  = RSRC_RDATA;
        state_d   = S_DRAIN;
      end
      S_DRAIN: begin
        if (res_cnt_q == 2'd0) begin
          state_d = S_IDLE;
        end else if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_idx  = drain_q;
          cmd_o.out_last = ({1'b0, drain_q} + 2'd1) == res_cnt_q;
          if (cmd_o.out_last) begin
            state_d = S_IDLE;
          end else begin
            drain_d = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (emit_en && res_cnt_q != 2'd2) begin
      cmd_o.res_push = 1'b1;
      cmd_o.res_idx  = res_cnt_q[0];
      cmd_o.res_kind = emit_kind;
      cmd_o.res_src  = emit_src;
      res_cnt_d      = res_cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ret_q     <= S_IDLE;
      aop_q     <= AOP_ADD;
      halted_q  <= 1'b0;
      res_cnt_q <= '0;
      drain_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      aop_q     <= aop_d;
      halted_q  <= halted_d;
      res_cnt_q <= res_cnt_d;
      drain_q   <= drain_d;
    end
  end

  assign in_ready_o = state_q == S_IDLE;

endmodule

`default_nettype wire

FILE: rtl/core/rpn_stack_calculator.sv
`default_nettype none

// Channel   Direction  tdata                      tuser            tlast
// s_axis    in         [7:0] char_code            -                end_of_stream
// m_axis    out        [63:0] result_value Q32.32 [2:0] result_kind last_of_run
//
// One character is taken per transaction; a finished number and '/' or '%' wait on the
// 96-step restoring divider, and '*' waits on the 32x32 multiplier. Reset is
// asynchronous and active low; the stack memory is not cleared. A waiting result in
// the output register does not block the next character, but up to two results per
// character drain into it one at a time, and the next character waits while the
// output side stalls.

module rpn_stack_calculator
  import rpnc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] char_code
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,  // [63:0] result_value
  output logic [2:0]       m_axis_tuser,  // [2:0] result_kind
  output logic             m_axis_tlast
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rpnc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rpnc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_char_i   (s_axis_tdata),
    .in_eos_i    (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_value_o (m_axis_tdata),
    .out_kind_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire
